// File: rtl/ipsc_pkg.sv
// ipsc_pkg: shared types, codes and constants for the inactivity power state controller
// used by every module in rtl/, depends on nothing
package ipsc_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int TICKS_W     = 20;
    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET  = TICKS_W'(60 * 1000);
    localparam logic [TICKS_W-1:0] OFF_TICKS_RESET   = TICKS_W'(5 * 60 * 1000);
    localparam logic [PCT_W-1:0]   IDLE_BRIGHT_RESET = PCT_W'(5);
    localparam logic [PCT_W-1:0]   PCT_MAX           = PCT_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BRIGHT = 2'd2;

    typedef enum logic [1:0] {
        PM_ACTIVE = 2'd0,
        PM_IDLE   = 2'd1,
        PM_OFF    = 2'd2
    } t_power_mode;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_ACTIVITY = 3'd1,
        FN_CHARGE   = 3'd2,
        FN_IDLE_NOW = 3'd3,
        FN_OFF_NOW  = 3'd4,
        FN_SET_AUTO = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_ENTER_IDLE    = 3'd1,
        ACT_EXIT_IDLE     = 3'd2,
        ACT_EXIT_IDLE_CHG = 3'd3,
        ACT_POWER_OFF     = 3'd4,
        ACT_CANCEL_CHG    = 3'd5,
        ACT_DEFERRED      = 3'd6
    } t_action;

    typedef struct packed {
        logic [2:0]       func;
        logic             charge_read_ok;
        logic             charger_active;
        logic             mode_undecided;
        logic             auto_value;
        logic [PCT_W-1:0] current_brightness;
    } t_item;

    typedef struct packed {
        logic [1:0]       power_state;
        logic [2:0]       action;
        logic             backlight_write;
        logic [PCT_W-1:0] backlight_value;
        logic             peripherals_reduced;
        logic             charging_exempt;
    } t_result;

    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

endpackage

// File: rtl/ipsc_in_stage.sv
// ipsc_in_stage: input register holding one word ahead of the state update
// depends on ipsc_pkg
module ipsc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ipsc_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output ipsc_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    ipsc_pkg::t_item r_item;
    logic            load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/ipsc_core.sv
// ipsc_core: configuration registers, power mode, countdowns and the single-pass update
// depends on ipsc_pkg
module ipsc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_fire,
    input  ipsc_pkg::t_item                     i_item,
    output ipsc_pkg::t_result                   o_result
);

    localparam int CW = ipsc_pkg::COUNT_WIDTH;
    localparam int PW = ipsc_pkg::PCT_W;

    logic [ipsc_pkg::TICKS_W-1:0] r_idle_ticks;
    logic [ipsc_pkg::TICKS_W-1:0] r_off_ticks;
    logic [PW-1:0]                r_idle_bright;

    ipsc_pkg::t_power_mode r_mode, n_mode;
    logic [CW-1:0]         r_idle_cnt, n_idle_cnt;
    logic [CW-1:0]         r_off_cnt, n_off_cnt;
    logic                  r_idle_armed, n_idle_armed;
    logic                  r_off_armed, n_off_armed;
    logic                  r_chg, n_chg;
    logic                  r_auto, n_auto;
    logic [PW-1:0]         r_saved, n_saved;

    logic [CW-1:0] idle_load;
    logic [CW-1:0] off_load;
    logic [PW-1:0] cur_sat;
    logic [PW-1:0] idle_sat;
    logic          restore;

    assign idle_load = CW'(r_idle_ticks);
    assign off_load  = CW'(r_off_ticks);
    assign cur_sat   = ipsc_pkg::sat_pct(i_item.current_brightness);
    assign idle_sat  = ipsc_pkg::sat_pct(r_idle_bright);
    // leaving idle restores the saved level only if the user left the dim level alone
    assign restore   = (cur_sat == idle_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_ticks  <= ipsc_pkg::IDLE_TICKS_RESET;
            r_off_ticks   <= ipsc_pkg::OFF_TICKS_RESET;
            r_idle_bright <= ipsc_pkg::IDLE_BRIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ipsc_pkg::CFG_IDLE_TICKS:  r_idle_ticks  <= i_cfg_data;
                ipsc_pkg::CFG_OFF_TICKS:   r_off_ticks   <= i_cfg_data;
                ipsc_pkg::CFG_IDLE_BRIGHT: r_idle_bright <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic          fire_idle;
        logic          fire_off;
        logic [2:0]    act;
        logic          wr;
        logic [PW-1:0] val;
        ipsc_pkg::t_func fn;

        fn           = ipsc_pkg::t_func'(i_item.func);
        n_mode       = r_mode;
        n_idle_cnt   = r_idle_cnt;
        n_off_cnt    = r_off_cnt;
        n_idle_armed = r_idle_armed;
        n_off_armed  = r_off_armed;
        n_chg        = r_chg;
        n_auto       = r_auto;
        n_saved      = r_saved;
        fire_idle    = 1'b0;
        fire_off     = 1'b0;
        act          = ipsc_pkg::ACT_NONE;
        wr           = 1'b0;
        val          = '0;

        case (fn)
            ipsc_pkg::FN_TICK: begin
                // a count of zero fires like a count of one
                if (r_idle_armed) begin
                    if (r_idle_cnt <= CW'(1)) begin
                        n_idle_armed = 1'b0;
                        fire_idle    = 1'b1;
                    end else begin
                        n_idle_cnt = r_idle_cnt - CW'(1);
                    end
                end
                if (r_off_armed) begin
                    if (r_off_cnt <= CW'(1)) begin
                        n_off_armed = 1'b0;
                        fire_off    = 1'b1;
                    end else begin
                        n_off_cnt = r_off_cnt - CW'(1);
                    end
                end
            end
            ipsc_pkg::FN_ACTIVITY: begin
                if (r_mode != ipsc_pkg::PM_OFF && r_auto && !r_chg) begin
                    n_idle_cnt   = idle_load;
                    n_off_cnt    = off_load;
                    n_idle_armed = 1'b1;
                    n_off_armed  = 1'b1;
                    if (r_mode == ipsc_pkg::PM_IDLE) begin
                        n_mode = ipsc_pkg::PM_ACTIVE;
                        act    = ipsc_pkg::ACT_EXIT_IDLE;
                        if (restore) begin
                            wr  = 1'b1;
                            val = r_saved;
                        end
                    end
                end
            end
            ipsc_pkg::FN_CHARGE: begin
                if (r_mode != ipsc_pkg::PM_OFF && i_item.charge_read_ok) begin
                    n_chg = i_item.charger_active;
                    if (r_chg != i_item.charger_active) begin
                        if (i_item.charger_active) begin
                            n_idle_armed = 1'b0;
                            n_off_armed  = 1'b0;
                            if (r_mode == ipsc_pkg::PM_IDLE) begin
                                n_mode = ipsc_pkg::PM_ACTIVE;
                                act    = ipsc_pkg::ACT_EXIT_IDLE_CHG;
                                if (restore) begin
                                    wr  = 1'b1;
                                    val = r_saved;
                                end
                            end else begin
                                act = ipsc_pkg::ACT_CANCEL_CHG;
                            end
                        end else begin
                            n_idle_cnt   = idle_load;
                            n_off_cnt    = off_load;
                            n_idle_armed = 1'b1;
                            n_off_armed  = 1'b1;
                        end
                    end
                end
            end
            ipsc_pkg::FN_IDLE_NOW: begin
                n_idle_armed = 1'b0;
                fire_idle    = 1'b1;
            end
            ipsc_pkg::FN_OFF_NOW: begin
                n_off_armed = 1'b0;
                fire_off    = 1'b1;
            end
            ipsc_pkg::FN_SET_AUTO: begin
                n_auto = i_item.auto_value;
                if (i_item.auto_value) begin
                    if (!r_chg) begin
                        n_idle_cnt   = idle_load;
                        n_off_cnt    = off_load;
                        n_idle_armed = 1'b1;
                        n_off_armed  = 1'b1;
                    end
                end else begin
                    n_idle_armed = 1'b0;
                    n_off_armed  = 1'b0;
                    if (r_mode == ipsc_pkg::PM_IDLE) begin
                        n_mode = ipsc_pkg::PM_ACTIVE;
                        act    = ipsc_pkg::ACT_EXIT_IDLE;
                        if (restore) begin
                            wr  = 1'b1;
                            val = r_saved;
                        end
                    end
                end
            end
            default: ;
        endcase

        // idle expiry goes first, off expiry may then override action and write
        if (fire_idle && n_mode == ipsc_pkg::PM_ACTIVE && n_auto) begin
            if (i_item.charge_read_ok) begin
                n_chg = i_item.charger_active;
            end
            if (i_item.charge_read_ok && i_item.charger_active) begin
                n_idle_armed = 1'b0;
                n_off_armed  = 1'b0;
                act          = ipsc_pkg::ACT_CANCEL_CHG;
            end else begin
                n_mode  = ipsc_pkg::PM_IDLE;
                n_saved = cur_sat;
                act     = ipsc_pkg::ACT_ENTER_IDLE;
                wr      = 1'b1;
                val     = (cur_sat != '0) ? idle_sat : '0;
            end
        end

        if (fire_off && n_mode != ipsc_pkg::PM_OFF && n_auto) begin
            if (i_item.charge_read_ok) begin
                n_chg = i_item.charger_active;
            end
            if (i_item.charge_read_ok && i_item.charger_active) begin
                n_idle_armed = 1'b0;
                n_off_armed  = 1'b0;
                act          = ipsc_pkg::ACT_CANCEL_CHG;
            end else if (i_item.mode_undecided) begin
                act = ipsc_pkg::ACT_DEFERRED;
            end else begin
                n_mode       = ipsc_pkg::PM_OFF;
                n_idle_armed = 1'b0;
                n_off_armed  = 1'b0;
                act          = ipsc_pkg::ACT_POWER_OFF;
                wr           = 1'b1;
                val          = '0;
            end
        end

        o_result.power_state         = n_mode;
        o_result.action              = act;
        o_result.backlight_write     = wr;
        o_result.backlight_value     = val;
        o_result.peripherals_reduced = (n_mode != ipsc_pkg::PM_ACTIVE);
        o_result.charging_exempt     = n_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ipsc_pkg::PM_ACTIVE;
            r_idle_cnt   <= CW'(ipsc_pkg::IDLE_TICKS_RESET);
            r_off_cnt    <= CW'(ipsc_pkg::OFF_TICKS_RESET);
            r_idle_armed <= 1'b1;
            r_off_armed  <= 1'b1;
            r_chg        <= 1'b0;
            r_auto       <= 1'b1;
            r_saved      <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_idle_cnt   <= n_idle_cnt;
            r_off_cnt    <= n_off_cnt;
            r_idle_armed <= n_idle_armed;
            r_off_armed  <= n_off_armed;
            r_chg        <= n_chg;
            r_auto       <= n_auto;
            r_saved      <= n_saved;
        end
    end

endmodule

// File: rtl/ipsc_out_stage.sv
// ipsc_out_stage: result register that holds a word until the consumer takes it
// depends on ipsc_pkg
module ipsc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ipsc_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output ipsc_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    ipsc_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: rtl/inactivity_power_state_controller.sv
// Inactivity power state controller: takes one word per clock cycle at full rate. Each
// word passes an input register, one pass through the countdown compare/decrement and the
// power mode update, and a result register, where the result is held until the consumer
// takes it; the throughput is one word per cycle, and only a stalled result port holds
// the input back. Configuration writes take effect at once and must be made while no
// word is in flight.
// top level: instantiates ipsc_in_stage, ipsc_core and ipsc_out_stage, uses ipsc_pkg
module inactivity_power_state_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_func,
    input  logic                            i_charge_read_ok,
    input  logic                            i_charger_active,
    input  logic                            i_mode_undecided,
    input  logic                            i_auto_value,
    input  logic [ipsc_pkg::PCT_W-1:0]      i_current_brightness,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_power_state,
    output logic [2:0]                      o_action,
    output logic                            o_backlight_write,
    output logic [ipsc_pkg::PCT_W-1:0]      o_backlight_value,
    output logic                            o_peripherals_reduced,
    output logic                            o_charging_exempt
);

    ipsc_pkg::t_item   in_item;
    ipsc_pkg::t_item   held_item;
    ipsc_pkg::t_result core_result;
    ipsc_pkg::t_result out_result;
    logic              held_valid;
    logic              out_free;
    logic              fire;

    assign in_item.func               = i_func;
    assign in_item.charge_read_ok     = i_charge_read_ok;
    assign in_item.charger_active     = i_charger_active;
    assign in_item.mode_undecided     = i_mode_undecided;
    assign in_item.auto_value         = i_auto_value;
    assign in_item.current_brightness = i_current_brightness;

    // a held word is processed as soon as the result register has room
    assign fire = held_valid && out_free;

    ipsc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    ipsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (held_item),
        .o_result   (core_result)
    );

    ipsc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_power_state         = out_result.power_state;
    assign o_action              = out_result.action;
    assign o_backlight_write     = out_result.backlight_write;
    assign o_backlight_value     = out_result.backlight_value;
    assign o_peripherals_reduced = out_result.peripherals_reduced;
    assign o_charging_exempt     = out_result.charging_exempt;

`ifndef SYNTHESIS
    a_off_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && core_result.action == ipsc_pkg::ACT_POWER_OFF)
            |-> (core_result.power_state == ipsc_pkg::PM_OFF && core_result.backlight_write))
        else $error("power off result without off state and backlight write");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !fire) |=> held_valid)
        else $error("held input word dropped before processing");

    a_no_write_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_backlight_write) |-> (o_backlight_value == '0))
        else $error("backlight value set without a write");

    a_reduced_tracks_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peripherals_reduced == (o_power_state != ipsc_pkg::PM_ACTIVE)))
        else $error("peripheral reduction out of step with power state");
`endif

endmodule
